/* sv/image_gradient_filter_macros.svh */
// Assertion macros for the image gradient filter.
// Used by image_gradient_filter.sv; expects clk and rst_n in scope.
`ifndef IMAGE_GRADIENT_FILTER_MACROS_SVH
`define IMAGE_GRADIENT_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define IGF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("igf: same-cycle check failed");
`define IGF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("igf: next-cycle check failed");
`else
`define IGF_ASSERT_NOW(label, ante, cons)
`define IGF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/igf_pkg.sv */
// Shared constants, codes and types of the image gradient filter.
// No dependencies.
package igf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 8;
  localparam int GRAD_BITS  = PIXEL_BITS + 3;
  localparam int SUM_BITS   = GRAD_BITS - 1;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int POS_W      = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 1;
  localparam int OPOS_W     = POS_W - 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic ACT_PIXEL  = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;
  localparam logic MODE_DIFF  = 1'b0;
  localparam logic MODE_SOBEL = 1'b1;

  typedef logic [PIXEL_BITS-1:0]    pix_t;
  typedef logic signed [GRAD_BITS-1:0] grad_t;

  // One item between the input stage and the window stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    pix_t             pix;
    logic [2:0]       row_ok;    // rows above, center, current inside the frame
    logic             first_col;
    logic             emit;
    logic             last;
  } s1_t;

endpackage

/* sv/igf_pix_if.sv */
// Input channel of the image gradient filter: valid/ready plus pixel item.
// Depends on igf_pkg.
interface igf_pix_if;
  import igf_pkg::*;

  logic valid;
  logic ready;
  logic action;
  pix_t pixel;

  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

/* sv/igf_grad_if.sv */
// Result channel of the image gradient filter: valid/ready plus gradients.
// Depends on igf_pkg.
interface igf_grad_if;
  import igf_pkg::*;

  logic  valid;
  logic  ready;
  grad_t grad_x;
  grad_t grad_y;
  logic  frame_end;

  modport source (output valid, grad_x, grad_y, frame_end, input ready);
  modport sink   (input valid, grad_x, grad_y, frame_end, output ready);
endinterface

/* sv/igf_ctrl.sv */
// Input stage: config registers, frame position counters, item decode.
// Depends on igf_pkg and igf_pix_if.
module igf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  igf_pix_if.sink                     in_pix,
  input  logic                        cfg_we,
  input  logic [igf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [igf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                        s1_adv,
  output logic                        s1_valid,
  output igf_pkg::s1_t                s1_q,
  output logic                        load,
  output logic [igf_pkg::COL_W-1:0]   rd_col,
  output logic                        mode
);
  import igf_pkg::*;

  logic              mode_r;
  logic [WID_W-1:0]  w_r;
  logic [HGT_W-1:0]  h_r;
  logic              hold_r;
  logic [POS_W-1:0]  total_r, total_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [OPOS_W-1:0] opos_r, opos_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              s1_valid_r;
  s1_t               s1_q_r, s1_nxt;

  logic              accept, drain, process_item, wrap, emit, last;
  logic [ROW_W:0]    row_x, h_x;
  logic [WID_W-1:0]  w_in;
  logic [HGT_W-1:0]  h_in;

  // saturated geometry from the write data
  always_comb begin
    w_in = cfg_data[WID_W-1:0];
    h_in = cfg_data[HGT_W-1:0];
    if (w_in == '0) w_in = WID_W'(1);
    else if (w_in > WID_W'(MAX_WIDTH)) w_in = WID_W'(MAX_WIDTH);
    if (h_in == '0) h_in = HGT_W'(1);
    else if (h_in > HGT_W'(MAX_HEIGHT)) h_in = HGT_W'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SOBEL;
      w_r    <= WID_W'(640);
      h_r    <= HGT_W'(480);
      hold_r <= 1'b1;
    end else begin
      hold_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:   mode_r <= cfg_data[0];
          REG_WIDTH:  w_r    <= w_in;
          REG_HEIGHT: h_r    <= h_in;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    in_pix.ready = s1_adv && !hold_r;
    accept       = in_pix.valid && in_pix.ready;
    drain        = pos_r >= total_r;
    process_item = !(in_pix.action == ACT_FLUSH && !drain);
    load         = accept && process_item;
    wrap         = ({1'b0, col_r} + WID_W'(1)) >= w_r;
    emit         = pos_r >= (POS_W'(w_r) + POS_W'(1));
    last         = ({1'b0, opos_r} + POS_W'(1)) >= total_r;
    row_x        = {1'b0, row_r};
    h_x          = (ROW_W + 1)'(h_r);

    s1_nxt.col       = col_r;
    s1_nxt.pix       = drain ? '0 : in_pix.pixel;
    s1_nxt.row_ok[0] = (row_x >= (ROW_W + 1)'(2)) && (row_x < h_x + (ROW_W + 1)'(2));
    s1_nxt.row_ok[1] = (row_x >= (ROW_W + 1)'(1)) && (row_x < h_x + (ROW_W + 1)'(1));
    s1_nxt.row_ok[2] = row_x < h_x;
    s1_nxt.first_col = col_r == '0;
    s1_nxt.emit      = emit;
    s1_nxt.last      = last;

    total_nxt = total_r;
    pos_nxt   = pos_r;
    opos_nxt  = opos_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    // in the cycle after a config write: rebuild frame size and linear position
    if (hold_r) begin
      total_nxt = POS_W'(w_r) * POS_W'(h_r);
      pos_nxt   = POS_W'(row_r) * POS_W'(w_r) + POS_W'(col_r);
    end
    if (load) begin
      if (wrap) begin
        col_nxt = '0;
        if (row_r != '1) row_nxt = row_r + ROW_W'(1);
        pos_nxt = pos_r - POS_W'(col_r) + POS_W'(w_r);
      end else begin
        col_nxt = col_r + COL_W'(1);
        pos_nxt = pos_r + POS_W'(1);
      end
      if (emit) begin
        if (last) begin
          col_nxt  = '0;
          row_nxt  = '0;
          pos_nxt  = '0;
          opos_nxt = '0;
        end else begin
          opos_nxt = opos_r + OPOS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      opos_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      opos_r <= opos_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      if (s1_adv) s1_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    if (s1_adv) s1_q_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_q     = s1_q_r;
  assign rd_col   = col_r;
  assign mode     = mode_r;

endmodule

/* sv/igf_line_buf.sv */
// Two row buffers (row above, center row) with write-to-read bypass.
// Depends on igf_pkg.
module igf_line_buf (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [igf_pkg::COL_W-1:0] rd_col,
  input  logic                      s1_valid,
  input  logic                      s1_adv,
  input  logic [igf_pkg::COL_W-1:0] s1_col,
  input  igf_pkg::pix_t             s1_pix,
  output igf_pkg::pix_t             above,
  output igf_pkg::pix_t             center
);
  import igf_pkg::*;

  pix_t above_mem  [MAX_WIDTH];
  pix_t center_mem [MAX_WIDTH];
  pix_t rd_a_r, rd_b_r, fa_r, fb_r;
  logic fwd_r;
  logic wr_en;

  assign wr_en  = s1_valid && s1_adv;
  assign above  = fwd_r ? fa_r : rd_a_r;
  assign center = fwd_r ? fb_r : rd_b_r;

  // center row moves up, new pixel becomes center
  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[s1_col]  <= center;
      center_mem[s1_col] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rd_a_r <= above_mem[rd_col];
      rd_b_r <= center_mem[rd_col];
      fa_r   <= center;
      fb_r   <= s1_pix;
    end
  end

  // same column written on the read edge (one-pixel rows): take the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (load) begin
      fwd_r <= s1_valid && (s1_col == rd_col);
    end
  end

endmodule

/* sv/igf_calc.sv */
// Window stage: 3x3 window shift, Sobel / difference kernels, result register.
// Depends on igf_pkg and igf_grad_if.
module igf_calc (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          mode,
  input  logic          s1_valid,
  input  igf_pkg::s1_t  s1_q,
  input  igf_pkg::pix_t above,
  input  igf_pkg::pix_t center,
  output logic          s1_adv,
  igf_grad_if.source    out_grad
);
  import igf_pkg::*;

  pix_t  win_r [3][2];   // [row][0] left column, [row][1] middle column
  pix_t  col_v [3];
  pix_t  o_l [3], o_m [3], o_r [3];
  logic  step;
  logic  out_valid_r;
  grad_t gx_r, gy_r;
  logic  fe_r;
  logic  [SUM_BITS-1:0] px_s, px_n, py_s, py_n;
  grad_t gx, gy;

  function automatic logic [SUM_BITS-1:0] wsum(pix_t x0, pix_t x1, pix_t x2);
    wsum = SUM_BITS'(x0) + SUM_BITS'({x1, 1'b0}) + SUM_BITS'(x2);
  endfunction

  function automatic logic [SUM_BITS-1:0] dsum(pix_t x0, pix_t x1);
    dsum = {(SUM_BITS-1)'(x0) + (SUM_BITS-1)'(x1), 1'b0};
  endfunction

  assign s1_adv = !s1_valid || !s1_q.emit || !out_valid_r || out_grad.ready;
  assign step   = s1_valid && s1_adv;

  always_comb begin
    col_v[0] = s1_q.row_ok[0] ? above  : '0;
    col_v[1] = s1_q.row_ok[1] ? center : '0;
    col_v[2] = s1_q.row_ok[2] ? s1_q.pix : '0;
    for (int i = 0; i < 3; i++) begin
      o_l[i] = win_r[i][0];
      o_m[i] = win_r[i][1];
      o_r[i] = s1_q.first_col ? '0 : col_v[i];
    end
    case (mode)
      MODE_SOBEL: begin
        px_s = wsum(o_r[0], o_r[1], o_r[2]);
        px_n = wsum(o_l[0], o_l[1], o_l[2]);
        py_s = wsum(o_l[2], o_m[2], o_r[2]);
        py_n = wsum(o_l[0], o_m[0], o_r[0]);
      end
      default: begin
        px_s = dsum(o_r[1], o_r[2]);
        px_n = dsum(o_m[1], o_m[2]);
        py_s = dsum(o_m[2], o_r[2]);
        py_n = dsum(o_m[1], o_r[1]);
      end
    endcase
    gx = grad_t'({1'b0, px_s}) - grad_t'({1'b0, px_n});
    gy = grad_t'({1'b0, py_s}) - grad_t'({1'b0, py_n});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= '0;
        win_r[i][1] <= '0;
      end
    end else if (step) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= s1_q.first_col ? '0 : o_m[i];
        win_r[i][1] <= col_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && s1_q.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_grad.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_q.emit) begin
      gx_r <= gx;
      gy_r <= gy;
      fe_r <= s1_q.last;
    end
  end

  assign out_grad.valid     = out_valid_r;
  assign out_grad.grad_x    = gx_r;
  assign out_grad.grad_y    = gy_r;
  assign out_grad.frame_end = fe_r;

endmodule

/* sv/image_gradient_filter.sv */
// Top level of the streaming image gradient filter (3x3 Sobel / 2x2 difference).
// Depends on igf_pkg, igf_pix_if, igf_grad_if, igf_ctrl, igf_line_buf, igf_calc
// and the assertion macros in image_gradient_filter_macros.svh.
`include "image_gradient_filter_macros.svh"

// Pixels enter in raster order, one per transfer; each result carries grad_x and
// grad_y scaled by four (exact integers, pixels outside the frame read as zero)
// and frame_end on the last pixel of the frame. Throughput is one item per clock
// while the output is taken and no configuration write holds the input: an item
// is taken in the input stage (counters, row buffer read) into the stage register,
// passes the window stage into the output register and can leave from there.
// A result belongs to the pixel one row plus one pixel earlier; after the last
// pixel of a frame send flush items (action = 1) to drain the rest. Flush items
// before the frame is complete are dropped. In the cycle after every configuration
// write the input is not ready while the frame size and position are recomputed.
// Two 1024 x 8 row buffers hold the previous rows; they need no clearing after
// reset.
module image_gradient_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  igf_pix_if.sink                        in_pix,
  igf_grad_if.source                     out_grad,
  input  logic                           cfg_we,
  input  logic [igf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [igf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import igf_pkg::*;

  logic             s1_valid;
  s1_t              s1_q;
  logic             s1_adv;
  logic             load;
  logic [COL_W-1:0] rd_col;
  logic             mode;
  pix_t             above, center;

  // counters, geometry, item decode
  igf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_adv    (s1_adv),
    .s1_valid  (s1_valid),
    .s1_q      (s1_q),
    .load      (load),
    .rd_col    (rd_col),
    .mode      (mode)
  );

  // row buffers, read on accept, written when the item leaves the window stage
  igf_line_buf u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .rd_col   (rd_col),
    .s1_valid (s1_valid),
    .s1_adv   (s1_adv),
    .s1_col   (s1_q.col),
    .s1_pix   (s1_q.pix),
    .above    (above),
    .center   (center)
  );

  // window shift, kernel, output register
  igf_calc u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode),
    .s1_valid (s1_valid),
    .s1_q     (s1_q),
    .above    (above),
    .center   (center),
    .s1_adv   (s1_adv),
    .out_grad (out_grad)
  );

  // no transfer in the recompute cycle after a config write
  `IGF_ASSERT_NEXT(a_cfg_hold, cfg_we, !(in_pix.valid && in_pix.ready))
  // a waiting result is never overwritten by the window stage
  `IGF_ASSERT_NOW(a_no_overrun, s1_valid && s1_q.emit && out_grad.valid && !out_grad.ready, !s1_adv && !in_pix.ready)

endmodule
